// ===== hdl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse unit
// Item structs, arithmetic widths, divider geometry and cofactor helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mi3_pkg;

	// Element and result widths.
	localparam int ELEM_W = 16;
	localparam int ADJ_W  = 33;
	localparam int DET_W  = 49;
	localparam int Q_W    = 32;
	localparam int MAG_W  = 32;

	// The numerator is |adj| scaled by 2^28, giving Q16.16 after the divide.
	localparam int FRAC_SHIFT = 28;
	localparam int NUM_W      = MAG_W + FRAC_SHIFT;
	localparam int DEN_W      = 48;

	// Divider geometry: two quotient bits per stage.
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = Q_W / DIV_STEP;

	// Cycles from an accepted item to its result strobe.
	localparam int LATENCY = 4 + 1 + DIV_STAGES + 1 + 1;

	localparam logic signed [Q_W-1:0] OUT_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic signed [Q_W-1:0] OUT_MIN = {1'b1, {(Q_W-1){1'b0}}};

	typedef struct packed {
		logic signed [ELEM_W-1:0] a00;
		logic signed [ELEM_W-1:0] a01;
		logic signed [ELEM_W-1:0] a02;
		logic signed [ELEM_W-1:0] a10;
		logic signed [ELEM_W-1:0] a11;
		logic signed [ELEM_W-1:0] a12;
		logic signed [ELEM_W-1:0] a20;
		logic signed [ELEM_W-1:0] a21;
		logic signed [ELEM_W-1:0] a22;
	} mat_t;

	typedef struct packed {
		logic signed [Q_W-1:0] r00;
		logic signed [Q_W-1:0] r01;
		logic signed [Q_W-1:0] r02;
		logic signed [Q_W-1:0] r10;
		logic signed [Q_W-1:0] r11;
		logic signed [Q_W-1:0] r12;
		logic signed [Q_W-1:0] r20;
		logic signed [Q_W-1:0] r21;
		logic signed [Q_W-1:0] r22;
		logic                  singular;
		logic                  saturated;
	} res_t;

	// Two-by-two cofactor x*y - z*w, exact in 33 bits.
	function automatic logic signed [ADJ_W-1:0] cof(
		input logic signed [ELEM_W-1:0] x,
		input logic signed [ELEM_W-1:0] y,
		input logic signed [ELEM_W-1:0] z,
		input logic signed [ELEM_W-1:0] w
	);
		logic signed [2*ELEM_W-1:0] p;
		logic signed [2*ELEM_W-1:0] q;
		p = (2*ELEM_W)'(x) * (2*ELEM_W)'(y);
		q = (2*ELEM_W)'(z) * (2*ELEM_W)'(w);
		return ADJ_W'(p) - ADJ_W'(q);
	endfunction

	// Element times cofactor, exact in 49 bits.
	function automatic logic signed [DET_W-1:0] mul_term(
		input logic signed [ELEM_W-1:0] x,
		input logic signed [ADJ_W-1:0]  y
	);
		return DET_W'(x) * DET_W'(y);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/mi3_div.sv =====
// ----------------------------------------------------------------------------
// mi3_div: pipelined signed divide with Q16.16 clamp
// Restoring divide of magnitudes, two quotient bits per stage, then sign
// and saturation. A zero determinant forces a zero result.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               valid,
	input  wire  [mi3_pkg::NUM_W-1:0]         num,
	input  wire  [mi3_pkg::DEN_W-1:0]         den,
	input  wire                               neg,
	input  wire                               zero,
	output logic                              done,
	output logic signed [mi3_pkg::Q_W-1:0]    quot,
	output logic                              sat,
	output logic                              singular
);
	import mi3_pkg::*;

	logic [DIV_STAGES:0] v_s;
	logic [DEN_W-1:0]    rem_s  [DIV_STAGES+1];
	logic [MAG_W-1:0]    low_s  [DIV_STAGES+1];
	logic [Q_W-1:0]      quo_s  [DIV_STAGES+1];
	logic [DEN_W-1:0]    den_s  [DIV_STAGES+1];
	logic [DIV_STAGES:0] neg_s;
	logic [DIV_STAGES:0] zero_s;
	logic [DIV_STAGES:0] ovf_s;

	// Entry stage: the quotient overflows 32 bits exactly when the upper
	// numerator part already reaches the divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= DEN_W'(num[NUM_W-1:MAG_W]);
		low_s[0]  <= num[MAG_W-1:0];
		quo_s[0]  <= '0;
		den_s[0]  <= den;
		neg_s[0]  <= neg;
		zero_s[0] <= zero;
		ovf_s[0]  <= DEN_W'(num[NUM_W-1:MAG_W]) >= den;
	end

	// Quotient stages, each retiring two bits.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		logic [DEN_W-1:0] rem_n;
		logic [MAG_W-1:0] low_n;
		logic [Q_W-1:0]   quo_n;

		always_comb begin
			logic [DEN_W:0] t;
			rem_n = rem_s[k-1];
			low_n = low_s[k-1];
			quo_n = quo_s[k-1];
			for (int i = 0; i < DIV_STEP; i++) begin
				t     = {rem_n, low_n[MAG_W-1]};
				low_n = {low_n[MAG_W-2:0], 1'b0};
				if (t >= {1'b0, den_s[k-1]}) begin
					t     = t - {1'b0, den_s[k-1]};
					quo_n = {quo_n[Q_W-2:0], 1'b1};
				end else begin
					quo_n = {quo_n[Q_W-2:0], 1'b0};
				end
				rem_n = t[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= rem_n;
			low_s[k]  <= low_n;
			quo_s[k]  <= quo_n;
			den_s[k]  <= den_s[k-1];
			neg_s[k]  <= neg_s[k-1];
			zero_s[k] <= zero_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
		end
	end

	// Sign and clamp.
	logic [Q_W-1:0]        qm;
	logic signed [Q_W-1:0] q_n;
	logic                  sat_n;

	always_comb begin
		qm    = quo_s[DIV_STAGES];
		q_n   = '0;
		sat_n = 1'b0;
		if (zero_s[DIV_STAGES]) begin
			q_n = '0;
		end else if (ovf_s[DIV_STAGES]) begin
			q_n   = neg_s[DIV_STAGES] ? OUT_MIN : OUT_MAX;
			sat_n = 1'b1;
		end else if (!neg_s[DIV_STAGES]) begin
			if (qm[Q_W-1]) begin
				q_n   = OUT_MAX;
				sat_n = 1'b1;
			end else begin
				q_n = qm;
			end
		end else begin
			if (qm > Q_W'(OUT_MIN)) begin
				q_n   = OUT_MIN;
				sat_n = 1'b1;
			end else begin
				q_n = -qm;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		quot     <= q_n;
		sat      <= sat_n;
		singular <= zero_s[DIV_STAGES];
	end

endmodule

`default_nettype wire

// ===== hdl/matrix_inverse_3x3_unit.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_unit: 3x3 matrix inverse by the adjugate
// Q3.12 matrix in, Q16.16 inverse out, with singular and saturated flags.
// ----------------------------------------------------------------------------
// One matrix item may be started in every clock cycle; busy is always low.
// Each result appears on result for one cycle with done high, in the order
// the items came in. On its way it passes the item register, the adjugate,
// expansion term and determinant stages, one divider entry stage, sixteen
// divider stages of two quotient bits each, the clamp stage and the output
// register. The receiver cannot stall the unit.
`default_nettype none

module matrix_inverse_3x3_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  mi3_pkg::mat_t       matrix,
	output logic                done,
	output mi3_pkg::res_t       result
);
	import mi3_pkg::*;

	localparam int N = 9;

	assign busy = 1'b0;

	logic                     v_s1, v_s2, v_s3, v_s4;
	mat_t                     mat_s1;
	logic signed [ELEM_W-1:0] a_s2, b_s2, c_s2;
	logic signed [ADJ_W-1:0]  adj_s2 [N];
	logic signed [ADJ_W-1:0]  adj_s3 [N];
	logic signed [ADJ_W-1:0]  adj_s4 [N];
	logic signed [DET_W-1:0]  t0_s3, t1_s3, t2_s3;
	logic signed [DET_W-1:0]  det_s4;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Stage 1 registers the item; stage 2 forms the adjugate, row-major.
	always_ff @(posedge clk) begin
		mat_s1    <= matrix;
		a_s2      <= mat_s1.a00;
		b_s2      <= mat_s1.a01;
		c_s2      <= mat_s1.a02;
		adj_s2[0] <= cof(mat_s1.a11, mat_s1.a22, mat_s1.a12, mat_s1.a21);
		adj_s2[1] <= cof(mat_s1.a02, mat_s1.a21, mat_s1.a01, mat_s1.a22);
		adj_s2[2] <= cof(mat_s1.a01, mat_s1.a12, mat_s1.a02, mat_s1.a11);
		adj_s2[3] <= cof(mat_s1.a12, mat_s1.a20, mat_s1.a10, mat_s1.a22);
		adj_s2[4] <= cof(mat_s1.a00, mat_s1.a22, mat_s1.a02, mat_s1.a20);
		adj_s2[5] <= cof(mat_s1.a02, mat_s1.a10, mat_s1.a00, mat_s1.a12);
		adj_s2[6] <= cof(mat_s1.a10, mat_s1.a21, mat_s1.a11, mat_s1.a20);
		adj_s2[7] <= cof(mat_s1.a01, mat_s1.a20, mat_s1.a00, mat_s1.a21);
		adj_s2[8] <= cof(mat_s1.a00, mat_s1.a11, mat_s1.a01, mat_s1.a10);
	end

	// Stage 3 forms the first-row expansion terms; stage 4 sums them.
	always_ff @(posedge clk) begin
		t0_s3  <= mul_term(a_s2, adj_s2[0]);
		t1_s3  <= mul_term(b_s2, adj_s2[3]);
		t2_s3  <= mul_term(c_s2, adj_s2[6]);
		adj_s3 <= adj_s2;
		det_s4 <= t0_s3 + t1_s3 + t2_s3;
		adj_s4 <= adj_s3;
	end

	// Magnitudes and signs for the dividers.
	logic [DET_W-1:0] det_abs;
	logic [DEN_W-1:0] den;
	logic             det_zero;

	assign det_abs  = det_s4[DET_W-1] ? DET_W'(-det_s4) : DET_W'(det_s4);
	assign den      = det_abs[DEN_W-1:0];
	assign det_zero = (det_s4 == '0);

	logic [N-1:0]          lane_done;
	logic [N-1:0]          lane_sat;
	logic [N-1:0]          lane_sing;
	logic signed [Q_W-1:0] lane_q [N];

	for (genvar n = 0; n < N; n++) begin : g_lane
		logic [ADJ_W-1:0] adj_abs;
		logic [NUM_W-1:0] num;

		assign adj_abs = adj_s4[n][ADJ_W-1] ? ADJ_W'(-adj_s4[n]) : ADJ_W'(adj_s4[n]);
		assign num     = {adj_abs[MAG_W-1:0], {FRAC_SHIFT{1'b0}}};

		mi3_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.valid    (v_s4),
			.num      (num),
			.den      (den),
			.neg      (adj_s4[n][ADJ_W-1] ^ det_s4[DET_W-1]),
			.zero     (det_zero),
			.done     (lane_done[n]),
			.quot     (lane_q[n]),
			.sat      (lane_sat[n]),
			.singular (lane_sing[n])
		);
	end

	// Output register gathers the nine lanes.
	logic done_q;
	res_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= &lane_done;
		end
	end

	always_ff @(posedge clk) begin
		result_q.r00       <= lane_q[0];
		result_q.r01       <= lane_q[1];
		result_q.r02       <= lane_q[2];
		result_q.r10       <= lane_q[3];
		result_q.r11       <= lane_q[4];
		result_q.r12       <= lane_q[5];
		result_q.r20       <= lane_q[6];
		result_q.r21       <= lane_q[7];
		result_q.r22       <= lane_q[8];
		result_q.singular  <= &lane_sing;
		result_q.saturated <= |lane_sat;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// ===== hdl/mi3_checker.sv =====
// ----------------------------------------------------------------------------
// mi3_checker: port-level checks for the matrix inverse unit
// Fixed latency, no spurious results, and clean singular results.
// ----------------------------------------------------------------------------
`default_nettype none

module mi3_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input mi3_pkg::mat_t matrix,
	input wire           done,
	input mi3_pkg::res_t result
);
	import mi3_pkg::*;

	// Every accepted item yields its result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result missing after accepted item");

	// A result strobe always traces back to an accepted item.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without matching item");

	// A singular result is all zero and never flagged saturated.
	a_singular: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.singular) |-> (!result.saturated && result.r00 == 0 &&
			result.r01 == 0 && result.r02 == 0 && result.r10 == 0 &&
			result.r11 == 0 && result.r12 == 0 && result.r20 == 0 &&
			result.r21 == 0 && result.r22 == 0))
		else $error("singular result not cleared");

endmodule

bind matrix_inverse_3x3_unit mi3_checker u_mi3_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 matrix inverse unit
// Drives Q3.12 matrices with random start gaps and checks each Q16.16
// inverse, singular and saturated flag against an in-bench adjugate predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mi3_pkg::*;

	localparam int NUM_RANDOM  = 2000;
	localparam int CYCLE_LIMIT = 200000;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	mat_t  matrix;
	logic  done;
	res_t  result;

	mat_t  pending_mats[$];
	res_t  expected_inverses[$];
	int    gap_left;
	int    mismatch_count;
	int    inverse_count;
	int    singular_count;
	int    saturated_count;
	int    cycle_count;
	bit    stimulus_done;

	matrix_inverse_3x3_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.matrix (matrix),
		.done   (done),
		.result (result)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Predict the inverse of one matrix by the adjugate over the determinant.
	function automatic res_t predict_inverse(input mat_t m);
		longint a, b, c, d, e, f, g, h, k, det, q;
		longint adj[9];
		res_t   r;
		a = longint'(m.a00); b = longint'(m.a01); c = longint'(m.a02);
		d = longint'(m.a10); e = longint'(m.a11); f = longint'(m.a12);
		g = longint'(m.a20); h = longint'(m.a21); k = longint'(m.a22);
		adj[0] = e * k - f * h;
		adj[1] = -(b * k - c * h);
		adj[2] = b * f - c * e;
		adj[3] = -(d * k - f * g);
		adj[4] = a * k - c * g;
		adj[5] = -(a * f - c * d);
		adj[6] = d * h - e * g;
		adj[7] = -(a * h - b * g);
		adj[8] = a * e - b * d;
		det = a * adj[0] + b * adj[3] + c * adj[6];
		r = '0;
		if (det == 0) begin
			r.singular = 1'b1;
			return r;
		end
		for (int n = 0; n < 9; n++) begin
			// SystemVerilog integer division truncates toward zero.
			q = (adj[n] * 64'sd268435456) / det;
			if (q > 64'sd2147483647) begin
				q = 64'sd2147483647;
				r.saturated = 1'b1;
			end else if (q < -64'sd2147483648) begin
				q = -64'sd2147483648;
				r.saturated = 1'b1;
			end
			r[2 + 32 * (8 - n) +: 32] = q[31:0];
		end
		return r;
	endfunction

	// Report one mismatch and count it.
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic logic signed [15:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			3: return 16'(int'($urandom_range(0, 8192)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic mat_t rand_matrix();
		mat_t m;
		int   kind;
		kind = $urandom_range(0, 9);
		m.a00 = rand_elem(); m.a01 = rand_elem(); m.a02 = rand_elem();
		m.a10 = rand_elem(); m.a11 = rand_elem(); m.a12 = rand_elem();
		m.a20 = rand_elem(); m.a21 = rand_elem(); m.a22 = rand_elem();
		// Some singular matrices: a repeated row or a zero column.
		if (kind == 0) begin
			m.a20 = m.a00; m.a21 = m.a01; m.a22 = m.a02;
		end else if (kind == 1) begin
			m.a01 = '0; m.a11 = '0; m.a21 = '0;
		end else if (kind == 2) begin
			// Near-diagonal, small off-diagonal: upper triangular, often tiny.
			m.a01 = 16'($urandom_range(0, 3)); m.a02 = '0;
			m.a10 = '0; m.a12 = 16'($urandom_range(0, 3));
			m.a20 = '0; m.a21 = '0;
		end
		return m;
	endfunction

	function automatic mat_t diag(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		mat_t m;
		m = '0;
		m.a00 = x; m.a11 = y; m.a22 = z;
		return m;
	endfunction

	// Stimulus: directed matrices, then random ones.
	initial begin
		mat_t m;
		arst_n = 1'b0;
		start = 1'b0;
		matrix = '0;
		stimulus_done = 1'b0;
		pending_mats.push_back(diag(16'sd4096, 16'sd4096, 16'sd4096));
		pending_mats.push_back(diag(16'sh8000, 16'sh8000, 16'sh8000));
		pending_mats.push_back(diag(16'sh7fff, 16'sh7fff, 16'sh7fff));
		pending_mats.push_back(diag(16'sd1, 16'sd1, 16'sd1));
		pending_mats.push_back(diag(-16'sd1, 16'sd1, 16'sd1));
		pending_mats.push_back(diag(16'sd3, -16'sd7, 16'sd4096));
		pending_mats.push_back(diag(16'sd4096, 16'sd0, 16'sd4096));
		pending_mats.push_back('0);
		m = '1;
		pending_mats.push_back(m);
		m = {9{16'sh7fff}};
		pending_mats.push_back(m);
		m = diag(16'sd4096, 16'sd4096, 16'sd4096);
		m.a01 = 16'sh7fff; m.a12 = 16'sh8000; m.a20 = 16'sd5;
		pending_mats.push_back(m);
		m = diag(16'sd1, 16'sd1, 16'sd1);
		m.a02 = 16'sh8000; m.a10 = 16'sh7fff;
		pending_mats.push_back(m);
		m = diag(16'sd3, 16'sd3, 16'sd3);
		m.a01 = 16'sd1; m.a12 = -16'sd1; m.a20 = 16'sd2;
		pending_mats.push_back(m);
		for (int i = 0; i < NUM_RANDOM; i++)
			pending_mats.push_back(rand_matrix());
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		stimulus_done = 1'b1;
	end

	// Driver: one matrix per start, either back to back or after a random gap.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else if (start && !busy) begin
			if (pending_mats.size() != 0 && $urandom_range(0, 1) == 0) begin
				matrix <= pending_mats.pop_front();
				start <= 1'b1;
				gap_left <= 0;
			end else begin
				start <= 1'b0;
				gap_left <= $urandom_range(0, 5);
			end
		end else if (!start) begin
			if (gap_left > 0)
				gap_left <= gap_left - 1;
			else if (pending_mats.size() != 0) begin
				matrix <= pending_mats.pop_front();
				start <= 1'b1;
			end
		end
	end

	// Monitor: record accepted matrices and check each strobed result.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			cycle_count++;
			if (start && !busy)
				expected_inverses.push_back(predict_inverse(matrix));
			if (done) begin
				if (expected_inverses.size() == 0) begin
					report_mismatch("result with nothing outstanding", 64'd1, 64'd0);
				end else begin
					want = expected_inverses.pop_front();
					inverse_count++;
					if (want.singular) singular_count++;
					if (want.saturated) saturated_count++;
					if (result.r00 !== want.r00)
						report_mismatch("r00", 64'(result.r00), 64'(want.r00));
					if (result.r01 !== want.r01)
						report_mismatch("r01", 64'(result.r01), 64'(want.r01));
					if (result.r02 !== want.r02)
						report_mismatch("r02", 64'(result.r02), 64'(want.r02));
					if (result.r10 !== want.r10)
						report_mismatch("r10", 64'(result.r10), 64'(want.r10));
					if (result.r11 !== want.r11)
						report_mismatch("r11", 64'(result.r11), 64'(want.r11));
					if (result.r12 !== want.r12)
						report_mismatch("r12", 64'(result.r12), 64'(want.r12));
					if (result.r20 !== want.r20)
						report_mismatch("r20", 64'(result.r20), 64'(want.r20));
					if (result.r21 !== want.r21)
						report_mismatch("r21", 64'(result.r21), 64'(want.r21));
					if (result.r22 !== want.r22)
						report_mismatch("r22", 64'(result.r22), 64'(want.r22));
					if (result.singular !== want.singular)
						report_mismatch("singular", 64'(result.singular),
							64'(want.singular));
					if (result.saturated !== want.saturated)
						report_mismatch("saturated", 64'(result.saturated),
							64'(want.saturated));
				end
			end
		end
	end

	// End of run: drain, wait out the pipeline, then give the verdict.
	initial begin
		mismatch_count = 0;
		inverse_count = 0;
		singular_count = 0;
		saturated_count = 0;
		cycle_count = 0;
		fork
			begin
				wait (stimulus_done);
				wait (pending_mats.size() == 0 && !start && expected_inverses.size() == 0);
				repeat (LATENCY + 10) @(posedge clk);
				if (expected_inverses.size() != 0)
					report_mismatch("results never arrived",
						64'(expected_inverses.size()), 64'd0);
				$display("Checked %0d inverses: %0d singular, %0d saturated.",
					inverse_count, singular_count, saturated_count);
				if (mismatch_count == 0)
					$display("No mismatches found");
				else
					$display("Mismatches found");
			end
			begin
				wait (cycle_count >= CYCLE_LIMIT);
				$display("Timeout after %0d cycles", cycle_count);
				$display("Mismatches found");
			end
		join_any
		$finish;
	end

endmodule

`default_nettype wire

// ===== matrix_inverse_3x3_unit.f =====
hdl/mi3_pkg.sv
hdl/mi3_div.sv
hdl/matrix_inverse_3x3_unit.sv
hdl/mi3_checker.sv
verif/testbench.sv
